// ----- hdl/lttu_pkg.sv -----
package lttu_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int ID_W            = 31;
	localparam int TIME_W          = 32;
	localparam int STATUS_W        = 4;
	localparam int TIMEOUT_W       = 16;
	localparam int SLOT_W          = 4;
	localparam int COUNT_W         = 5;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd35;
	localparam logic [STATUS_W-1:0]  OFFLINE_RST = 4'd6;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_OFFLINE = 1'b1;

	localparam logic FUNC_MSG  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_ADDED     = 3'd1,
		EV_REFRESHED = 3'd2,
		EV_REMOVED   = 3'd3,
		EV_TIMEOUT   = 3'd4
	} ev_kind_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_SKIP,
		OP_MSG,
		OP_OFF
	} op_t;

	typedef struct packed {
		logic                func;
		logic [ID_W-1:0]     client_id;
		logic [STATUS_W-1:0] client_status;
	} item_t;

	typedef struct packed {
		ev_kind_t            event_kind;
		logic [SLOT_W-1:0]   slot;
		logic [ID_W-1:0]     entry_id;
		logic [STATUS_W-1:0] entry_status;
		logic [COUNT_W-1:0]  entry_count;
		logic                all_gone;
		logic                last_result;
	} result_t;

	typedef struct packed {
		op_t                 op;
		logic [ID_W-1:0]     id;
		logic [STATUS_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout;
		logic [STATUS_W-1:0]  offline;
	} cfg_t;

endpackage

// ----- hdl/lttu_cfg.sv -----
module lttu_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lttu_pkg::APB_AW-1:0]   paddr,
	input  logic [lttu_pkg::APB_DW-1:0]   pwdata,
	output logic [lttu_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output lttu_pkg::cfg_t                cfg
);
	import lttu_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout <= TIMEOUT_RST;
			cfg_q.offline <= OFFLINE_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_TIMEOUT: cfg_q.timeout <= pwdata[TIMEOUT_W-1:0];
				REG_OFFLINE: cfg_q.offline <= pwdata[STATUS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TIMEOUT: prdata = {{(APB_DW-TIMEOUT_W){1'b0}}, cfg_q.timeout};
			REG_OFFLINE: prdata = {{(APB_DW-STATUS_W){1'b0}}, cfg_q.offline};
			default:     prdata = '0;
		endcase
	end

endmodule

// ----- hdl/lttu_front.sv -----
module lttu_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  lttu_pkg::item_t            item,
	input  logic [lttu_pkg::STATUS_W-1:0] offline,
	output lttu_pkg::cmd_t             cmd,
	output logic                       cmd_valid,
	input  logic                       cmd_pop
);
	import lttu_pkg::*;

	cmd_t       q_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cls;

	// classify the item before it is queued
	always_comb begin
		cls.id     = item.client_id;
		cls.status = item.client_status;
		priority if (item.func == FUNC_TICK) begin
			cls.op = OP_TICK;
		end else if (item.client_id == '0) begin
			cls.op = OP_SKIP;
		end else if (item.client_status == offline) begin
			cls.op = OP_OFF;
		end else begin
			cls.op = OP_MSG;
		end
	end

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign cmd       = q_q[rd_q];
	assign cmd_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hdl/lttu_back.sv -----
module lttu_back #(
	parameter int TABLE_DEPTH = lttu_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lttu_pkg::cfg_t    cfg,
	input  lttu_pkg::cmd_t    cmd,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	output logic              result_valid,
	output lttu_pkg::result_t result
);
	import lttu_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] heard;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPLY,
		ST_SWEEP,
		ST_FLUSH
	} state_t;

	entry_t mem [TABLE_DEPTH];

	state_t            state_q;
	cmd_t              cmd_q;
	logic [CW-1:0]     count_q;
	logic [TIME_W-1:0] clock_q;
	logic              seen_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     wptr_q;
	logic [CW-1:0]     nrd_q;
	logic              found_vld_q;
	logic [AW-1:0]     found_q;
	logic              drop_vld_q;
	logic              pend_vld_q;
	result_t           pend_q;
	result_t           result_q;
	logic              result_valid_q;

	entry_t            rd_s1;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_idx_s1;

	logic              issue;
	logic [AW-1:0]     rd_addr;
	logic              hit;
	logic              last_idx;
	logic [TIME_W-1:0] idle;
	logic              expired;
	logic              skip_drop;
	logic              room;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_data;
	logic              ev_vld;
	result_t           ev;
	logic [CW-1:0]     count_nx;
	result_t           none_res;
	result_t           last_res;

	assign rd_addr   = ptr_q[AW-1:0];
	assign issue     = ((state_q == ST_SEARCH) && (ptr_q < count_q))
		|| ((state_q == ST_SWEEP) && (ptr_q < nrd_q));
	assign hit       = rd_vld_s1 && (rd_s1.id == cmd_q.id);
	assign last_idx  = (CW'(rd_idx_s1) == (count_q - CW'(1)));
	assign idle      = clock_q - rd_s1.heard;
	assign expired   = (idle >= {{(TIME_W-TIMEOUT_W){1'b0}}, cfg.timeout});
	assign skip_drop = drop_vld_q && (rd_idx_s1 == found_q);
	assign room      = (count_q < CW'(TABLE_DEPTH));
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;

	assign result       = result_q;
	assign result_valid = result_valid_q;

	// table write port and event of this cycle
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = found_q;
		wr_data  = '{id: cmd_q.id, heard: clock_q};
		ev_vld   = 1'b0;
		count_nx = count_q;
		ev       = '0;
		ev.entry_id     = cmd_q.id;
		ev.entry_status = cmd_q.status;
		ev.slot         = SLOT_W'(found_q);
		unique case (state_q)
			ST_APPLY: begin
				if (cmd_q.op == OP_OFF) begin
					if (found_vld_q) begin
						ev_vld        = 1'b1;
						ev.event_kind = EV_REMOVED;
						count_nx      = count_q - CW'(1);
					end
				end else if (found_vld_q) begin
					wr_en         = 1'b1;
					ev_vld        = 1'b1;
					ev.event_kind = EV_REFRESHED;
				end else if (room) begin
					wr_en         = 1'b1;
					wr_addr       = count_q[AW-1:0];
					ev_vld        = 1'b1;
					ev.event_kind = EV_ADDED;
					ev.slot       = SLOT_W'(count_q[AW-1:0]);
					count_nx      = count_q + CW'(1);
				end
			end
			ST_SWEEP: begin
				if (rd_vld_s1 && !skip_drop) begin
					if (expired) begin
						ev_vld          = 1'b1;
						ev.event_kind   = EV_TIMEOUT;
						ev.slot         = SLOT_W'(wptr_q);
						ev.entry_id     = rd_s1.id;
						ev.entry_status = '0;
						count_nx        = count_q - CW'(1);
					end else begin
						wr_en   = 1'b1;
						wr_addr = wptr_q[AW-1:0];
						wr_data = rd_s1;
					end
				end
			end
			default: ;
		endcase
		ev.entry_count = COUNT_W'(count_nx);
		ev.all_gone    = (count_nx == '0) && seen_q;
		ev.last_result = 1'b0;
	end

	always_comb begin
		none_res             = '0;
		none_res.event_kind  = EV_NONE;
		none_res.entry_count = COUNT_W'(count_q);
		none_res.all_gone    = (count_q == '0) && seen_q;
		none_res.last_result = 1'b1;
		last_res             = pend_q;
		last_res.last_result = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_s1     <= mem[rd_addr];
		rd_idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cmd_q          <= '0;
			count_q        <= '0;
			clock_q        <= '0;
			seen_q         <= 1'b0;
			ptr_q          <= '0;
			wptr_q         <= '0;
			nrd_q          <= '0;
			found_vld_q    <= 1'b0;
			found_q        <= '0;
			drop_vld_q     <= 1'b0;
			pend_vld_q     <= 1'b0;
			pend_q         <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
			rd_vld_s1      <= 1'b0;
		end else begin
			result_valid_q <= (ev_vld && pend_vld_q) || (state_q == ST_FLUSH);
			rd_vld_s1      <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (ev_vld) begin
				if (pend_vld_q) begin
					result_q <= pend_q;
				end
				pend_q     <= ev;
				pend_vld_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q       <= cmd;
						ptr_q       <= '0;
						wptr_q      <= '0;
						nrd_q       <= count_q;
						found_vld_q <= 1'b0;
						drop_vld_q  <= 1'b0;
						unique case (cmd.op)
							OP_TICK: begin
								clock_q <= clock_q + TIME_W'(1);
								state_q <= ST_SWEEP;
							end
							OP_SKIP: state_q <= ST_SWEEP;
							OP_MSG, OP_OFF: begin
								seen_q  <= 1'b1;
								state_q <= (count_q == '0) ? ST_APPLY : ST_SEARCH;
							end
							default: state_q <= ST_SWEEP;
						endcase
					end
				end
				ST_SEARCH: begin
					priority if (hit) begin
						found_vld_q <= 1'b1;
						found_q     <= rd_idx_s1;
						state_q     <= ST_APPLY;
					end else if (rd_vld_s1 && last_idx) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					count_q    <= count_nx;
					ptr_q      <= '0;
					drop_vld_q <= (cmd_q.op == OP_OFF) && found_vld_q;
					nrd_q      <= (count_nx > count_q) ? count_nx : count_q;
					state_q    <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (rd_vld_s1 && !skip_drop) begin
						if (expired) begin
							count_q <= count_nx;
						end else begin
							wptr_q <= wptr_q + CW'(1);
						end
					end
					if (!issue && !rd_vld_s1) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					result_q   <= pend_vld_q ? last_res : none_res;
					pend_vld_q <= 1'b0;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/liveness_table_with_timeout_unit.sv -----
// a tick or an ignored message runs only the timeout sweep; a message runs the id search
// (skipped with an empty table), an apply step and then the sweep; the search and the sweep
// each scan the table through one read port, so an item takes longer with more live entries
// events are held back by one so the last can be marked; the receiver cannot stall, and a
// two-item queue takes start while the engine works; reset empties the table, zeroes the
// clock, loads 35, 6
module liveness_table_with_timeout_unit #(
	parameter int TABLE_DEPTH = lttu_pkg::TABLE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  lttu_pkg::item_t             item,
	output logic                        result_valid,
	output lttu_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lttu_pkg::APB_AW-1:0] paddr,
	input  logic [lttu_pkg::APB_DW-1:0] pwdata,
	output logic [lttu_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import lttu_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	lttu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lttu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.offline   (cfg.offline),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	lttu_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
